@@ hw/rtl/atrs_pkg.sv @@
`timescale 1ns / 1ps

package atrs_pkg;

  localparam int unsigned STEPS_PER_DEGREE_DEF = 16;
  localparam int unsigned TRIG_FRAC_BITS_DEF   = 14;

  localparam int unsigned XY_W      = 32;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned M_W       = 32;
  localparam int unsigned S_TDATA_W = 2 * XY_W + ANGLE_W + 2 * SCALE_W;
  localparam int unsigned M_TDATA_W = 6 * M_W;

  // Which quarter-wave entry feeds sin and cos, and their signs.
  typedef struct packed {
    logic odd;
    logic sin_neg;
    logic cos_neg;
  } quad_t;

endpackage

@@ hw/rtl/atrs_sine_rom.sv @@
`timescale 1ns / 1ps

module atrs_sine_rom #(
  parameter int unsigned QUARTER_STEPS = 90 * atrs_pkg::STEPS_PER_DEGREE_DEF,
  parameter int unsigned FRAC_BITS     = atrs_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [$clog2(QUARTER_STEPS + 1)-1:0]  addr0_i,
  input  logic [$clog2(QUARTER_STEPS + 1)-1:0]  addr1_i,
  output logic [FRAC_BITS:0]                    data0_o,
  output logic [FRAC_BITS:0]                    data1_o
);

  localparam int unsigned Depth = QUARTER_STEPS + 1;
  localparam int unsigned DataW = FRAC_BITS + 1;
  localparam real         Pi    = 3.14159265358979323846;
  localparam real         Step  = Pi / (2.0 * QUARTER_STEPS);
  localparam real         Scale = 2.0 ** FRAC_BITS;

  typedef logic [DataW-1:0] rom_t [Depth];

  // Entry k holds sin(k * 90 degrees / QUARTER_STEPS) rounded to nearest.
  function automatic rom_t build_rom();
    rom_t t;
    real  v;
    for (int k = 0; k < Depth; k++) begin
      v    = $sin(real'(k) * Step) * Scale;
      t[k] = DataW'(int'(v));
    end
    return t;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [DataW-1:0] data0_q;
  logic [DataW-1:0] data1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data0_q <= Rom[addr0_i];
      data1_q <= Rom[addr1_i];
    end
  end

  assign data0_o = data0_q;
  assign data1_o = data1_q;

endmodule

@@ hw/rtl/atrs_rot_scale.sv @@
`timescale 1ns / 1ps

module atrs_rot_scale #(
  parameter int unsigned TRIG_FRAC_BITS = atrs_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic [TRIG_FRAC_BITS:0]                   d0_i,
  input  logic [TRIG_FRAC_BITS:0]                   d1_i,
  input  atrs_pkg::quad_t                           quad_i,
  input  logic signed [atrs_pkg::SCALE_W-1:0]       scale_x_i,
  input  logic signed [atrs_pkg::SCALE_W-1:0]       scale_y_i,
  output logic signed [atrs_pkg::M_W-1:0]           m00_o,
  output logic signed [atrs_pkg::M_W-1:0]           m01_o,
  output logic signed [atrs_pkg::M_W-1:0]           m10_o,
  output logic signed [atrs_pkg::M_W-1:0]           m11_o
);

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned PW = TW + atrs_pkg::SCALE_W;
  localparam int unsigned SH = TRIG_FRAC_BITS - 8;
  localparam logic signed [PW-1:0] Half = (SH > 0) ? PW'(1 << (SH - 1)) : '0;

  logic [TRIG_FRAC_BITS:0] sin_mag;
  logic [TRIG_FRAC_BITS:0] cos_mag;
  logic signed [TW-1:0]    sin_pos;
  logic signed [TW-1:0]    cos_pos;
  logic signed [TW-1:0]    sin_s;
  logic signed [TW-1:0]    nsin_s;
  logic signed [TW-1:0]    cos_s;
  logic signed [PW-1:0]    p00;
  logic signed [PW-1:0]    p01;
  logic signed [PW-1:0]    p10;
  logic signed [PW-1:0]    p11;

  assign sin_mag = quad_i.odd ? d1_i : d0_i;
  assign cos_mag = quad_i.odd ? d0_i : d1_i;
  assign sin_pos = $signed({1'b0, sin_mag});
  assign cos_pos = $signed({1'b0, cos_mag});

  assign sin_s  = quad_i.sin_neg ? -sin_pos : sin_pos;
  assign nsin_s = quad_i.sin_neg ? sin_pos : -sin_pos;
  assign cos_s  = quad_i.cos_neg ? -cos_pos : cos_pos;

  assign p00 = cos_s * scale_x_i;
  assign p01 = nsin_s * scale_y_i;
  assign p10 = sin_s * scale_x_i;
  assign p11 = cos_s * scale_y_i;

  // Round to nearest with ties toward plus infinity: add half, then floor.
  assign m00_o = atrs_pkg::M_W'((p00 + Half) >>> SH);
  assign m01_o = atrs_pkg::M_W'((p01 + Half) >>> SH);
  assign m10_o = atrs_pkg::M_W'((p10 + Half) >>> SH);
  assign m11_o = atrs_pkg::M_W'((p11 + Half) >>> SH);

endmodule

@@ hw/rtl/affine_2d_trs_matrix_builder.sv @@
`timescale 1ns / 1ps
// Channel   Dir  tdata bits  Contents
// s_axis    in   112         one transform request: translation, angle, scales
// m_axis    out  192         six non-constant entries of the composed 4x4 matrix
//
// One request per cycle unless output stalls have filled every stage.
// The stages are: input register, turn reduction by reciprocal multiply,
// quadrant fold, registered quarter-wave sine ROM read, products and rounding.
// Reset clears only the stage valid bits; the payload registers are left alone.
// Each stage moves when it is empty or the stage after it moves, so bubbles close up
// under output stalls and s_axis_tready stays high while any stage is empty.

module affine_2d_trs_matrix_builder #(
  parameter int unsigned STEPS_PER_DEGREE = atrs_pkg::STEPS_PER_DEGREE_DEF,
  parameter int unsigned TRIG_FRAC_BITS   = atrs_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // move_x[31:0], move_y[63:32], angle[79:64], scale_x[95:80], scale_y[111:96]
  input  logic [atrs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // m00[31:0], m01[63:32], m03[95:64], m10[127:96], m11[159:128], m13[191:160]
  output logic [atrs_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned Quarter = 90 * STEPS_PER_DEGREE;
  localparam int unsigned Full    = 4 * Quarter;
  localparam int unsigned Offset  = Full * ((32768 + Full - 1) / Full);
  localparam int unsigned XMax    = Offset + 32767;
  localparam int unsigned XW      = $clog2(XMax + 1);
  localparam int unsigned QW      = $clog2(XMax / Full + 1);
  localparam int unsigned RW      = $clog2(Full);
  localparam int unsigned AW      = $clog2(Quarter + 1);
  localparam logic [31:0] Recip   = 32'((64'd1 << 32) / Full);

  localparam int unsigned XY_W    = atrs_pkg::XY_W;
  localparam int unsigned ANGLE_W = atrs_pkg::ANGLE_W;
  localparam int unsigned SCALE_W = atrs_pkg::SCALE_W;
  localparam int unsigned M_W     = atrs_pkg::M_W;

  // Stage handshake.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Pass-through fields, one copy per stage that still needs them.
  logic        [XY_W-1:0]    mx1_q, mx2_q, mx3_q, mx4_q, mx5_q;
  logic        [XY_W-1:0]    my1_q, my2_q, my3_q, my4_q, my5_q;
  logic signed [SCALE_W-1:0] sx1_q, sx2_q, sx3_q, sx4_q;
  logic signed [SCALE_W-1:0] sy1_q, sy2_q, sy3_q, sy4_q;
  logic signed [ANGLE_W-1:0] ang1_q;

  // Stage 1: bias the angle to a non-negative value and estimate the turn count.
  logic [XW-1:0]    x1;
  logic [XW+31:0]   prod1;
  logic [QW-1:0]    qe1;

  assign x1    = XW'(int'(ang1_q) + int'(Offset));
  assign prod1 = (XW + 32)'(x1) * (XW + 32)'(Recip);
  assign qe1   = QW'(prod1 >> 32);

  // Stage 2: the estimate is at most one short, so one correction finishes the modulo.
  logic [XW-1:0] x2_q;
  logic [QW-1:0] qe2_q;
  logic [XW-1:0] sub2;
  logic [RW-1:0] r2;

  assign sub2 = x2_q - XW'(int'(qe2_q) * int'(Full));
  assign r2   = (sub2 >= XW'(Full)) ? RW'(sub2 - XW'(Full)) : RW'(sub2);

  // Stage 3: fold into a quadrant; sin and cos share the two table addresses.
  logic [RW-1:0]   r3_q;
  logic [1:0]      quad3;
  logic [RW-1:0]   w3;
  logic [AW-1:0]   a0;
  logic [AW-1:0]   a1;
  atrs_pkg::quad_t qinfo3;

  always_comb begin
    if (r3_q >= RW'(3 * Quarter)) begin
      quad3 = 2'd3;
      w3    = r3_q - RW'(3 * Quarter);
    end else if (r3_q >= RW'(2 * Quarter)) begin
      quad3 = 2'd2;
      w3    = r3_q - RW'(2 * Quarter);
    end else if (r3_q >= RW'(Quarter)) begin
      quad3 = 2'd1;
      w3    = r3_q - RW'(Quarter);
    end else begin
      quad3 = 2'd0;
      w3    = r3_q;
    end
  end

  assign a0             = AW'(w3);
  assign a1             = AW'(Quarter) - AW'(w3);
  assign qinfo3.odd     = quad3[0];
  assign qinfo3.sin_neg = quad3[1];
  assign qinfo3.cos_neg = quad3[0] ^ quad3[1];

  // Stage 4: table data arrives registered next to the quadrant info.
  atrs_pkg::quad_t         qinfo4_q;
  logic [TRIG_FRAC_BITS:0] d0;
  logic [TRIG_FRAC_BITS:0] d1;

  atrs_sine_rom #(
    .QUARTER_STEPS (Quarter),
    .FRAC_BITS     (TRIG_FRAC_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .en_i    (rdy4 && v3_q),
    .addr0_i (a0),
    .addr1_i (a1),
    .data0_o (d0),
    .data1_o (d1)
  );

  logic signed [M_W-1:0] m00_4, m01_4, m10_4, m11_4;

  atrs_rot_scale #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_scale (
    .d0_i      (d0),
    .d1_i      (d1),
    .quad_i    (qinfo4_q),
    .scale_x_i (sx4_q),
    .scale_y_i (sy4_q),
    .m00_o     (m00_4),
    .m01_o     (m01_4),
    .m10_o     (m10_4),
    .m11_o     (m11_4)
  );

  // Stage 5: result register.
  logic [M_W-1:0] m00_q, m01_q, m10_q, m11_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      mx1_q  <= s_axis_tdata[31:0];
      my1_q  <= s_axis_tdata[63:32];
      ang1_q <= s_axis_tdata[79:64];
      sx1_q  <= s_axis_tdata[95:80];
      sy1_q  <= s_axis_tdata[111:96];
    end
    if (rdy2 && v1_q) begin
      x2_q  <= x1;
      qe2_q <= qe1;
      mx2_q <= mx1_q;
      my2_q <= my1_q;
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
    end
    if (rdy3 && v2_q) begin
      r3_q  <= r2;
      mx3_q <= mx2_q;
      my3_q <= my2_q;
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
    end
    if (rdy4 && v3_q) begin
      qinfo4_q <= qinfo3;
      mx4_q    <= mx3_q;
      my4_q    <= my3_q;
      sx4_q    <= sx3_q;
      sy4_q    <= sy3_q;
    end
    if (rdy5 && v4_q) begin
      m00_q <= m00_4;
      m01_q <= m01_4;
      m10_q <= m10_4;
      m11_q <= m11_4;
      mx5_q <= mx4_q;
      my5_q <= my4_q;
    end
  end

  assign m_axis_tdata = {my5_q, m11_q, m10_q, mx5_q, m01_q, m00_q};

endmodule

@@ hw/rtl/atrs_checker.sv @@
`timescale 1ns / 1ps

module atrs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [atrs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned Stages = 5;

  logic       in_fire;
  logic       out_fire;
  logic [3:0] count_q;
  logic [3:0] count_d;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    count_d = count_q;
    if (in_fire && !out_fire) begin
      count_d = count_q + 4'd1;
    end else if (out_fire && !in_fire) begin
      count_d = count_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> count_q != 4'd0)
    else $error("result shown with no request outstanding");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 4'(Stages))
    else $error("more requests in flight than pipeline stages");

endmodule

bind affine_2d_trs_matrix_builder atrs_checker u_atrs_checker (.*);
